// ----- rtl/rrn_pkg.sv -----
// ----------------------------------------------------------------------------
// rrn_pkg: shared types and constants of the RMS row normalizer
// Holds the payload structs, the inter-module control structs, the state
// enums and the fixed sizes used by every module of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package rrn_pkg;

  localparam int unsigned ROW_MAX     = 4096;
  localparam int unsigned CNT_W       = $clog2(ROW_MAX + 1);
  localparam int unsigned SUM_W       = 48;
  localparam int unsigned FACTOR_W    = 32;
  localparam int unsigned EPS_W       = 16;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

  // Shared divider: 49-bit dividend (2^48 at most) and divisor.
  localparam int unsigned DIV_W       = 49;
  localparam int unsigned DIV_STEPS   = DIV_W;
  localparam int unsigned ROOT_W      = DIV_W + 1;
  localparam int unsigned SQRT_STEPS  = (DIV_W + 1) / 2;
  localparam int unsigned STEP_W      = $clog2(DIV_STEPS);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    CMD_ACCUMULATE = 1'b0,
    CMD_NORMALIZE  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] sample;
    logic signed [15:0] gain;
    logic               row_end;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] normalized;
    logic               row_done;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } fct_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [FACTOR_W-1:0] factor;
  } fct_rsp_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MEAN,
    F_RECIP,
    F_SQRT
  } fct_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_WAIT_F,
    B_MUL2,
    B_OUT
  } back_state_e;

endpackage

`default_nettype wire

// ----- rtl/rrn_front.sv -----
// ----------------------------------------------------------------------------
// rrn_front: input stage and item queue
// Takes command transfers and holds them in a short queue until the back
// end is free to carry them out.
// ----------------------------------------------------------------------------
`default_nettype none

module rrn_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire rrn_pkg::in_item_t item_i,
  output      logic              full_o,
  output      logic              valid_o,
  output      rrn_pkg::in_item_t item_o,
  input  wire logic              pop_i
);
  import rrn_pkg::*;

  in_item_t          slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = do_push ? wptr_q + QPTR_W'(1) : wptr_q;
    rptr_d = do_pop ? rptr_q + QPTR_W'(1) : rptr_q;
    cnt_d  = cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rrn_factor.sv -----
// ----------------------------------------------------------------------------
// rrn_factor: inverse square root sequencer
// Forms floor(sqrt(floor(2^48 / (sum/count + epsilon)))) with one shared
// restoring divider (one quotient bit a cycle) and a bit-serial square root.
// ----------------------------------------------------------------------------
`default_nettype none

module rrn_factor (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [rrn_pkg::EPS_W-1:0]   eps_i,
  input  wire rrn_pkg::fct_req_t           req_i,
  output      rrn_pkg::fct_rsp_t           rsp_o
);
  import rrn_pkg::*;

  fct_state_e          state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [DIV_W-1:0]    dvd_q, dvd_d, dsr_q, dsr_d;
  logic [DIV_W:0]      rem_q, rem_d;
  logic [DIV_W-1:0]    x_q, x_d, bit_q, bit_d;
  logic [ROOT_W-1:0]   root_q, root_d;
  logic [FACTOR_W-1:0] factor_q, factor_d;
  logic                done_q, done_d;

  logic [DIV_W:0]      rem_sh;
  logic                div_ge;
  logic [DIV_W-1:0]    quot;
  logic [DIV_W:0]      ms;
  logic [ROOT_W-1:0]   trial;
  logic                sq_ge;
  logic                div_last, sqrt_last;

  assign rem_sh    = {rem_q[DIV_W-1:0], dvd_q[DIV_W-1]};
  assign div_ge    = rem_sh >= {1'b0, dsr_q};
  assign quot      = {dvd_q[DIV_W-2:0], div_ge};
  assign ms        = {1'b0, quot} + (DIV_W+1)'(eps_i);
  assign trial     = root_q + ROOT_W'(bit_q);
  assign sq_ge     = ROOT_W'(x_q) >= trial;
  assign div_last  = (step_q == STEP_W'(DIV_STEPS - 1));
  assign sqrt_last = (step_q == STEP_W'(SQRT_STEPS - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:  if (req_i.start) state_d = F_MEAN;
      F_MEAN:  if (div_last) state_d = (ms == '0) ? F_IDLE : F_RECIP;
      F_RECIP: if (div_last) state_d = F_SQRT;
      F_SQRT:  if (sqrt_last) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  // Datapath.
  always_comb begin
    step_d   = step_q + STEP_W'(1);
    dvd_d    = dvd_q;
    dsr_d    = dsr_q;
    rem_d    = rem_q;
    x_d      = x_q;
    bit_d    = bit_q;
    root_d   = root_q;
    factor_d = factor_q;
    done_d   = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        step_d = '0;
        rem_d  = '0;
        if (req_i.count == '0) begin
          // An empty row divides as a zero mean.
          dvd_d = '0;
          dsr_d = DIV_W'(1);
        end else begin
          dvd_d = DIV_W'(req_i.sum);
          dsr_d = DIV_W'(req_i.count);
        end
      end
      F_MEAN, F_RECIP: begin
        rem_d = div_ge ? rem_sh - {1'b0, dsr_q} : rem_sh;
        dvd_d = quot;
        if (div_last) begin
          step_d = '0;
          rem_d  = '0;
          if (state_q == F_MEAN) begin
            dvd_d = DIV_W'(1) << (DIV_W - 1);
            dsr_d = ms[DIV_W-1:0];
            if (ms == '0) begin
              factor_d = '1;
              done_d   = 1'b1;
            end
          end else begin
            x_d    = quot;
            root_d = '0;
            bit_d  = DIV_W'(1) << (DIV_W - 1);
          end
        end
      end
      F_SQRT: begin
        x_d    = sq_ge ? DIV_W'(ROOT_W'(x_q) - trial) : x_q;
        root_d = sq_ge ? (root_q >> 1) + ROOT_W'(bit_q) : root_q >> 1;
        bit_d  = bit_q >> 2;
        if (sqrt_last) begin
          factor_d = root_d[FACTOR_W-1:0];
          done_d   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q   <= step_d;
    dvd_q    <= dvd_d;
    dsr_q    <= dsr_d;
    rem_q    <= rem_d;
    x_q      <= x_d;
    bit_q    <= bit_d;
    root_q   <= root_d;
    factor_q <= factor_d;
  end

  assign rsp_o.busy   = (state_q != F_IDLE) || done_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.factor = factor_q;

endmodule

`default_nettype wire

// ----- rtl/rrn_back.sv -----
// ----------------------------------------------------------------------------
// rrn_back: execution stage
// Pops queued items, accumulates squares, hands row ends to the factor unit
// and scales normalize items through two registered multiplies.
// ----------------------------------------------------------------------------
`default_nettype none

module rrn_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire rrn_pkg::in_item_t   item_i,
  output      logic                pop_o,
  output      rrn_pkg::fct_req_t   fct_req_o,
  input  wire rrn_pkg::fct_rsp_t   fct_rsp_i,
  output      logic                done_o,
  output      rrn_pkg::out_item_t  result_o
);
  import rrn_pkg::*;

  back_state_e         state_q, state_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [FACTOR_W-1:0] factor_q;
  logic [47:0]         p1_q;
  logic [63:0]         p2_q;
  logic [15:0]         mg_q;
  logic                neg_q, last_q;
  out_item_t           res_q, res_d;
  logic                done_q;

  logic                take;
  logic [15:0]         ms_abs, mg_abs;
  logic [31:0]         sq;
  logic [SUM_W-1:0]    acc_sum;
  logic [CNT_W-1:0]    acc_cnt;
  logic                room;
  logic [34:0]         rnd;

  assign take   = (state_q == B_IDLE) && valid_i && !fct_rsp_i.busy;
  assign ms_abs = item_i.sample[15] ? 16'(-item_i.sample) : item_i.sample;
  assign mg_abs = item_i.gain[15] ? 16'(-item_i.gain) : item_i.gain;
  assign sq     = 32'(ms_abs) * 32'(ms_abs);
  assign room   = (cnt_q < CNT_W'(ROW_MAX));
  assign acc_sum = room ? sum_q + SUM_W'(sq) : sum_q;
  assign acc_cnt = room ? cnt_q + CNT_W'(1) : cnt_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (take) begin
          if (item_i.cmd == CMD_NORMALIZE) state_d = B_MUL2;
          else if (item_i.row_end) state_d = B_WAIT_F;
        end
      end
      B_WAIT_F: if (fct_rsp_i.done) state_d = B_IDLE;
      B_MUL2:   state_d = B_OUT;
      B_OUT:    state_d = B_IDLE;
      default:  state_d = B_IDLE;
    endcase
  end

  // Outputs and accumulator updates.
  always_comb begin
    pop_o           = take;
    fct_req_o.start = 1'b0;
    fct_req_o.sum   = acc_sum;
    fct_req_o.count = acc_cnt;
    sum_d           = sum_q;
    cnt_d           = cnt_q;
    if (take && item_i.cmd == CMD_ACCUMULATE) begin
      if (item_i.row_end) begin
        fct_req_o.start = 1'b1;
        sum_d           = '0;
        cnt_d           = '0;
      end else begin
        sum_d = acc_sum;
        cnt_d = acc_cnt;
      end
    end
  end

  // Round half away from zero on the magnitude, then saturate.
  assign rnd = 35'((p2_q + 64'(1 << 29)) >> 30);
  always_comb begin
    res_d.row_done = last_q;
    if (neg_q && p2_q != '0) begin
      res_d.normalized = (rnd > 35'd32768) ? 16'sh8000 : 16'(17'h10000 - 17'(rnd));
    end else begin
      res_d.normalized = (rnd > 35'd32767) ? 16'sh7fff : 16'(rnd);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      sum_q    <= '0;
      cnt_q    <= '0;
      factor_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      done_q  <= (state_q == B_OUT);
      if (fct_rsp_i.done) begin
        factor_q <= fct_rsp_i.factor;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      p1_q   <= 48'(ms_abs) * 48'(factor_q);
      mg_q   <= mg_abs;
      neg_q  <= item_i.sample[15] ^ item_i.gain[15];
      last_q <= item_i.row_end;
    end
    if (state_q == B_MUL2) begin
      p2_q <= 64'(p1_q) * 64'(mg_q);
    end
    if (state_q == B_OUT) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

// ----- rtl/rms_row_normalizer.sv -----
// ----------------------------------------------------------------------------
// rms_row_normalizer: two-pass RMS normalization of one row
// An item is taken when start is high and busy is low; it enters a
// four-entry queue, so busy rises only when that queue is full. The back
// end takes one accumulate item per cycle while the factor unit is idle.
// A normalize item is popped with the first registered multiply and holds
// the back end through the second multiply and the round and saturate;
// its result shows on result_o in the cycle after that for exactly one
// cycle with done_o high, and the receiver cannot stall it. A row_end
// accumulate item holds the back end while the factor unit runs a 49-step
// division and, if mean+epsilon is nonzero, another and a 25-step root.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_row_normalizer (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output      logic                      busy,
  input  wire rrn_pkg::in_item_t         item_i,
  output      logic                      done_o,
  output      rrn_pkg::out_item_t        result_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [rrn_pkg::EPS_W-1:0] cfg_wdata_i
);
  import rrn_pkg::*;

  logic [EPS_W-1:0] eps_q;
  logic             q_valid, q_pop;
  in_item_t         q_item;
  fct_req_t         fct_req;
  fct_rsp_t         fct_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_RESET;
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  rrn_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start),
    .item_i  (item_i),
    .full_o  (busy),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  rrn_factor u_factor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .eps_i  (eps_q),
    .req_i  (fct_req),
    .rsp_o  (fct_rsp)
  );

  rrn_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (q_valid),
    .item_i    (q_item),
    .pop_o     (q_pop),
    .fct_req_o (fct_req),
    .fct_rsp_i (fct_rsp),
    .done_o    (done_o),
    .result_o  (result_o)
  );

  // A result passes through the B_MUL2 and B_OUT states, so two strobes never touch.
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobes in back-to-back cycles");

  // Nothing leaves the queue while the factor unit works.
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fct_rsp.busy |-> !q_pop) else $error("queue popped during factor run");

  // A factor run starts only when the unit is free.
  a_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fct_req.start |-> !fct_rsp.busy) else $error("factor started while busy");

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the RMS row normalizer
// Drives a table of directed rows and then random rows (accumulate pass,
// normalize pass, some noise) with random gaps, writes epsilon between
// phases, and compares every result with an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rrn_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES  = 200;

  typedef struct {
    logic        cmd;
    logic [15:0] sample;
    logic [15:0] gain;
    logic        row_end;
    logic        has_exp;
    logic [15:0] exp_norm;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  item_i = '0;
  logic      done_o;
  out_item_t result_o;
  logic      cfg_we_i = 1'b0;
  logic [EPS_W-1:0] cfg_wdata_i = '0;

  // Predictor state.
  logic [15:0] eps_q;
  logic [47:0] sq_sum_q;
  int unsigned elem_cnt_q;
  logic [31:0] factor_q;

  out_item_t   expected_results[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  rms_row_normalizer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] scale_sample(input logic [15:0] s, input logic [15:0] g,
                                               input logic [31:0] f);
    logic        neg;
    logic [63:0] ms;
    logic [63:0] mg;
    logic [63:0] prod;
    logic [63:0] r;
    neg = s[15] ^ g[15];
    ms = s[15] ? 64'(-$signed({48'hFFFFFFFFFFFF, s})) : 64'(s);
    mg = g[15] ? 64'(-$signed({48'hFFFFFFFFFFFF, g})) : 64'(g);
    prod = ms * 64'(f) * mg;
    r = (prod + (64'd1 << 29)) >> 30;
    if (prod == 0) neg = 1'b0;
    if (neg) begin
      if (r > 32768) r = 32768;
      return 16'(17'h10000 - r);
    end
    if (r > 32767) r = 32767;
    return r[15:0];
  endfunction

  // Advances the predictor by one accepted item; returns 1 when a result is due.
  function automatic bit normalize_step(input in_item_t it, output out_item_t res);
    logic [63:0] mag;
    logic [63:0] ms;
    res = '0;
    if (it.cmd == CMD_ACCUMULATE) begin
      if (elem_cnt_q < ROW_MAX) begin
        mag = it.sample[15] ? 64'(-$signed({48'hFFFFFFFFFFFF, it.sample})) : 64'(it.sample);
        sq_sum_q = 48'(64'(sq_sum_q) + mag * mag);
        elem_cnt_q++;
      end
      if (it.row_end) begin
        ms = ((elem_cnt_q != 0) ? 64'(sq_sum_q) / elem_cnt_q : 64'd0) + 64'(eps_q);
        factor_q = (ms == 0) ? 32'hFFFFFFFF : 32'(isqrt64((64'd1 << 48) / ms));
        sq_sum_q = '0;
        elem_cnt_q = 0;
      end
      return 1'b0;
    end
    res.normalized = scale_sample(it.sample, it.gain, factor_q);
    res.row_done = it.row_end;
    return 1'b1;
  endfunction

  // Start stays high between items without a gap; drain_and_settle drops it.
  task automatic send_item(input in_item_t it, input bit has_exp, input logic [15:0] want);
    out_item_t res;
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_i <= it;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (normalize_step(it, res)) begin
      if (has_exp && res.normalized !== want)
        report_mismatch("table entry", 32'(res.normalized), 32'(want));
      expected_results.push_back(res);
    end
    @(negedge clk_i);
  endtask

  task automatic drain_and_settle();
    start <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_epsilon(input logic [15:0] v);
    drain_and_settle();
    cfg_wdata_i <= v;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    eps_q = v;
  endtask

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(-$signed(16'($urandom_range(0, 1024))));
      3: return 16'($urandom_range(0, 1024));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_row();
    in_item_t it;
    int unsigned len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      it.cmd = CMD_ACCUMULATE;
      it.sample = rand_value();
      it.gain = 16'($urandom);
      it.row_end = (i == len - 1);
      send_item(it, 1'b0, '0);
    end
    for (int i = 0; i < len; i++) begin
      it.cmd = CMD_NORMALIZE;
      it.sample = rand_value();
      it.gain = rand_value();
      it.row_end = (i == len - 1);
      send_item(it, 1'b0, '0);
    end
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(result_o), 32'h0);
      end else begin
        want = expected_results.pop_front();
        if (result_o.normalized !== want.normalized)
          report_mismatch("normalized", 32'(result_o.normalized), 32'(want.normalized));
        if (result_o.row_done !== want.row_done)
          report_mismatch("row_done", 32'(result_o.row_done), 32'(want.row_done));
      end
    end
  end

  // Watchdog: cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || cfg_we_i || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("rms_row_normalizer verification failed");
      $finish;
    end
  end

  stim_row_t directed[$];

  initial begin
    in_item_t it;
    eps_q = EPS_RESET;
    sq_sum_q = '0;
    elem_cnt_q = 0;
    factor_q = '0;
    // Normalize before any factor gives zero.
    directed.push_back('{1'b1, 16'h7FFF, 16'h7FFF, 1'b0, 1'b1, 16'h0000});
    directed.push_back('{1'b1, 16'h8000, 16'h8000, 1'b1, 1'b1, 16'h0000});
    // A row of extremes, then normalize it.
    directed.push_back('{1'b0, 16'h8000, 16'h0000, 1'b0, 1'b0, 16'h0});
    directed.push_back('{1'b0, 16'h7FFF, 16'hFFFF, 1'b0, 1'b0, 16'h0});
    directed.push_back('{1'b0, 16'h0000, 16'h8000, 1'b1, 1'b0, 16'h0});
    directed.push_back('{1'b1, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 16'h0});
    directed.push_back('{1'b1, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 16'h0});
    directed.push_back('{1'b1, 16'h0100, 16'h4000, 1'b0, 1'b0, 16'h0});
    directed.push_back('{1'b1, 16'h0000, 16'h8000, 1'b1, 1'b1, 16'h0000});
    // Small row: the factor grows large and the outputs saturate.
    directed.push_back('{1'b0, 16'h0001, 16'h0000, 1'b1, 1'b0, 16'h0});
    directed.push_back('{1'b1, 16'h7FFF, 16'h7FFF, 1'b0, 1'b1, 16'h7FFF});
    directed.push_back('{1'b1, 16'h7FFF, 16'h8000, 1'b1, 1'b1, 16'h8000});

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      it.cmd = directed[i].cmd;
      it.sample = directed[i].sample;
      it.gain = directed[i].gain;
      it.row_end = directed[i].row_end;
      send_item(it, directed[i].has_exp, directed[i].exp_norm);
    end

    // Zero mean square: epsilon 0 with all-zero samples saturates the factor.
    write_epsilon(16'h0000);
    it = '{CMD_ACCUMULATE, 16'h0000, 16'h0000, 1'b1};
    send_item(it, 1'b0, '0);
    it = '{CMD_NORMALIZE, 16'h0001, 16'h0001, 1'b1};
    send_item(it, 1'b0, '0);

    // Random phases with several epsilon settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_epsilon(16'h0001);
        1: write_epsilon(16'hFFFF);
        2: write_epsilon(16'h0000);
        default: write_epsilon(16'($urandom));
      endcase
      for (int r = 0; r < 21; r++) begin
        if ($urandom_range(0, 7) == 0) begin
          // Noise: stray items outside a well-formed row.
          it.cmd = $urandom_range(0, 1);
          it.sample = 16'($urandom);
          it.gain = 16'($urandom);
          it.row_end = $urandom_range(0, 1);
          send_item(it, 1'b0, '0);
        end else begin
          random_row();
        end
      end
    end

    drain_and_settle();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("rms_row_normalizer verification clean");
    end else begin
      $display("rms_row_normalizer verification failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
